### rtl/swr_pkg.sv
package swr_pkg;

    localparam int DW          = 64;
    localparam int DIV_CNT_W   = $clog2(DW + 1);
    localparam int LOAD_SCALE  = 100;
    localparam int FRAC_STEPS  = 7;
    localparam int FRAC_W      = DW + FRAC_STEPS;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_BINS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_CYCLES    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_CYCLES = 2'd2;

    localparam logic [4:0]    RST_ACTIVE_BINS   = 5'd16;
    localparam logic [31:0]   RST_BIN_CYCLES    = 32'd1000;
    localparam logic [31:0]   RST_WINDOW_CYCLES = 32'd15000;
    localparam logic [DW-1:0] SAT31             = 64'h0000_0000_7FFF_FFFF;

    typedef struct packed {
        logic        action;
        logic [63:0] now;
        logic [31:0] value_sum;
        logic [31:0] sample_count;
    } t_item;

    typedef struct packed {
        logic [63:0] window_sum;
        logic [63:0] window_count;
        logic [63:0] peak_sum;
        logic [63:0] peak_count;
        logic [63:0] total_sum;
        logic [63:0] total_count;
        logic [30:0] load_percent;
        logic [30:0] window_avg;
        logic [30:0] total_avg;
    } t_result;

    typedef struct packed {
        logic [63:0] sum;
        logic [63:0] cnt;
    } t_bin;

    typedef enum logic [1:0] {
        DIV_K,
        DIV_MODN,
        DIV_W,
        DIV_T
    } t_div_sel;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECIDE,
        S_FC_RD,
        S_FC_FOLD,
        S_K_WAIT,
        S_NORM,
        S_FOLD,
        S_PEAK,
        S_FIN,
        S_MOD_WAIT,
        S_ADD_RD,
        S_ADD_WR,
        S_W,
        S_W_WAIT,
        S_FRAC,
        S_T,
        S_T_WAIT,
        S_OUT
    } t_state;

    typedef struct packed {
        logic     load_item;
        logic     clear_all;
        logic     full_clear;
        logic     fold_cur;
        logic     div_start;
        t_div_sel div_sel;
        logic     set_k;
        logic     norm;
        logic     next;
        logic     fold_step;
        logic     peak;
        logic     mod_fix;
        logic     dl_adv;
        logic     add_wr;
        logic     frac_init;
        logic     frac_step;
        logic     cap_t;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        logic act_clear;
        logic past;
        logic far;
        logic div_busy;
        logic k_gt_n;
        logic norm_req;
        logic steps_done;
        logic w_zero;
        logic t_zero;
        logic frac_done;
    } t_stat;

endpackage

### rtl/swr_ram.sv
module swr_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

### rtl/swr_div.sv
module swr_div
    import swr_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [DW-1:0] i_divisor,
    output logic          o_busy,
    output logic [DW-1:0] o_quo,
    output logic [DW-1:0] o_rem
);

    // Restoring divider, one quotient bit per cycle.
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DW-1:0]        r_rem;
    logic [DW-1:0]        r_quo;
    logic [DW-1:0]        r_dvs;
    logic [DW:0]          n_trial;

    assign n_trial = {r_rem, r_quo[DW-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= DIV_CNT_W'(DW);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_cnt != '0) begin
            if (n_trial >= {1'b0, r_dvs}) begin
                r_rem <= DW'(n_trial - {1'b0, r_dvs});
                r_quo <= {r_quo[DW-2:0], 1'b1};
            end else begin
                r_rem <= n_trial[DW-1:0];
                r_quo <= {r_quo[DW-2:0], 1'b0};
            end
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

### rtl/swr_ctrl.sv
module swr_ctrl
    import swr_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_item_valid,
    output logic  o_item_ready,
    output logic  o_res_valid,
    input  logic  i_res_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_res_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_res_valid <= o_cmd.out_load | (r_res_valid & ~i_res_ready);
        end
    end

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_cmd.div_sel = DIV_K;
        o_item_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_item_ready = 1'b1;
                if (i_item_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_stat.act_clear) begin
                    o_cmd.full_clear = 1'b1;
                    o_cmd.clear_all  = 1'b1;
                    n_state = S_W;
                end else if (!i_stat.past) begin
                    n_state = S_ADD_RD;
                end else if (i_stat.far) begin
                    n_state = S_FC_RD;
                end else begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = DIV_K;
                    n_state = S_K_WAIT;
                end
            end
            S_FC_RD: n_state = S_FC_FOLD;
            S_FC_FOLD: begin
                o_cmd.fold_cur   = 1'b1;
                o_cmd.full_clear = 1'b1;
                n_state = S_ADD_RD;
            end
            S_K_WAIT: begin
                if (!i_stat.div_busy) begin
                    o_cmd.set_k = 1'b1;
                    n_state = S_NORM;
                end
            end
            S_NORM: begin
                if (i_stat.norm_req) begin
                    o_cmd.norm = 1'b1;
                end else begin
                    n_state = S_FOLD;
                end
            end
            S_FOLD: begin
                o_cmd.fold_step = 1'b1;
                n_state = S_PEAK;
            end
            S_PEAK: begin
                o_cmd.peak = 1'b1;
                if (i_stat.steps_done) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.next = 1'b1;
                    n_state = S_NORM;
                end
            end
            S_FIN: begin
                o_cmd.dl_adv = 1'b1;
                if (i_stat.k_gt_n) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = DIV_MODN;
                    n_state = S_MOD_WAIT;
                end else begin
                    n_state = S_ADD_RD;
                end
            end
            S_MOD_WAIT: begin
                o_cmd.div_sel = DIV_MODN;
                if (!i_stat.div_busy) begin
                    o_cmd.mod_fix = 1'b1;
                    n_state = S_ADD_RD;
                end
            end
            S_ADD_RD: n_state = S_ADD_WR;
            S_ADD_WR: begin
                o_cmd.add_wr = 1'b1;
                n_state = S_W;
            end
            S_W: begin
                if (i_stat.w_zero) begin
                    n_state = S_T;
                end else begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = DIV_W;
                    n_state = S_W_WAIT;
                end
            end
            S_W_WAIT: begin
                if (!i_stat.div_busy) begin
                    o_cmd.frac_init = 1'b1;
                    n_state = S_FRAC;
                end
            end
            S_FRAC: begin
                if (i_stat.frac_done) begin
                    n_state = S_T;
                end else begin
                    o_cmd.frac_step = 1'b1;
                end
            end
            S_T: begin
                if (i_stat.t_zero) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = DIV_T;
                    n_state = S_T_WAIT;
                end
            end
            S_T_WAIT: begin
                if (!i_stat.div_busy) begin
                    o_cmd.cap_t = 1'b1;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_res_valid || i_res_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_res_valid = r_res_valid;

endmodule

### rtl/swr_dp.sv
module swr_dp
    import swr_pkg::*;
#(
    parameter int MAX_BINS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_item                 i_item,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    output t_result               o_res
);

    localparam int IW = $clog2(MAX_BINS);
    localparam int NB = $clog2(MAX_BINS + 1);

    // configuration
    logic [4:0]  r_active_bins;
    logic [31:0] r_bin_cycles;
    logic [31:0] r_window_cycles;

    // architectural state
    logic [MAX_BINS-1:0] r_vld;
    logic [IW-1:0]       r_cur;
    logic [63:0]         r_dl;
    logic [63:0]         r_win_sum;
    logic [63:0]         r_win_cnt;
    logic [63:0]         r_peak_sum;
    logic [63:0]         r_peak_cnt;
    logic [63:0]         r_tot_sum;
    logic [63:0]         r_tot_cnt;

    // working registers
    t_item           r_item;
    logic [31:0]     r_k;
    logic [NB-1:0]   r_cnt;
    logic [NB-1:0]   r_tmp;
    logic [63:0]     r_prod;
    logic            r_va;
    logic            r_vb;
    logic [DW-1:0]   r_wq;
    logic [DW-1:0]   r_tq;
    logic [FRAC_W-1:0] r_fr;
    logic [FRAC_W-1:0] r_fd;
    logic [FRAC_STEPS-1:0] r_frac;
    logic [2:0]      r_fi;

    logic [8:0]    n_bins9;
    logic [NB-1:0] n_bins;
    logic [31:0]   n_len;
    logic [63:0]   n_gap;
    logic [31:0]   n_knew;
    logic [NB:0]   n_modsum;
    t_bin          n_qa;
    t_bin          n_qb;
    t_bin          n_bin_a;
    t_bin          n_bin_b;
    t_bin          n_wdata;
    logic [63:0]   n_win_sum;
    logic [63:0]   n_win_cnt;
    logic [DW-1:0] n_dividend;
    logic [DW-1:0] n_divisor;
    logic          div_busy;
    logic [DW-1:0] div_quo;
    logic [DW-1:0] div_rem;
    logic [38:0]   n_load;
    logic [30:0]   n_load_sat;

    // effective bin count and bin length
    always_comb begin
        n_bins9 = {4'b0, r_active_bins};
        if (n_bins9 < 9'd2) begin
            n_bins9 = 9'd2;
        end else if (n_bins9 > 9'(MAX_BINS)) begin
            n_bins9 = 9'(MAX_BINS);
        end
    end
    assign n_bins = n_bins9[NB-1:0];
    assign n_len  = (r_bin_cycles == '0) ? 32'd1 : r_bin_cycles;
    assign n_gap  = r_item.now - r_dl;
    assign n_knew = div_quo[31:0] + 32'd1;

    // bin store: sums and counts, zero unless the entry's valid bit is set
    swr_ram #(
        .WIDTH ($bits(t_bin)),
        .DEPTH (MAX_BINS)
    ) u_bins (
        .i_clk     (i_clk),
        .i_we      (i_cmd.add_wr),
        .i_waddr   (r_cur),
        .i_wdata   (n_wdata),
        .i_raddr_a (r_cur),
        .i_raddr_b (r_tmp[IW-1:0]),
        .o_rdata_a (n_qa),
        .o_rdata_b (n_qb)
    );

    assign n_bin_a = r_va ? n_qa : '0;
    assign n_bin_b = r_vb ? n_qb : '0;
    assign n_wdata.sum = n_bin_a.sum + 64'(r_item.value_sum);
    assign n_wdata.cnt = n_bin_a.cnt + 64'(r_item.sample_count);
    assign n_win_sum = r_win_sum + (n_bin_a.sum - n_bin_b.sum);
    assign n_win_cnt = r_win_cnt + (n_bin_a.cnt - n_bin_b.cnt);
    assign n_modsum  = {1'b0, NB'(r_cur)} + {1'b0, div_rem[NB-1:0]};

    // shared divider operand select
    always_comb begin
        case (i_cmd.div_sel)
            DIV_K: begin
                n_dividend = n_gap - 64'd1;
                n_divisor  = 64'(n_len);
            end
            DIV_MODN: begin
                n_dividend = 64'(r_k - 32'(n_bins));
                n_divisor  = 64'(n_bins);
            end
            DIV_W: begin
                n_dividend = r_win_sum;
                n_divisor  = r_win_cnt;
            end
            default: begin
                n_dividend = r_tot_sum;
                n_divisor  = r_tot_cnt;
            end
        endcase
    end

    swr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (n_dividend),
        .i_divisor  (n_divisor),
        .o_busy     (div_busy),
        .o_quo      (div_quo),
        .o_rem      (div_rem)
    );

    // state with a defined reset value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_bins   <= RST_ACTIVE_BINS;
            r_bin_cycles    <= RST_BIN_CYCLES;
            r_window_cycles <= RST_WINDOW_CYCLES;
            r_vld           <= '0;
            r_cur           <= '0;
            r_dl            <= '0;
            r_win_sum       <= '0;
            r_win_cnt       <= '0;
            r_peak_sum      <= '0;
            r_peak_cnt      <= '0;
            r_tot_sum       <= '0;
            r_tot_cnt       <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_ACTIVE_BINS:   r_active_bins   <= i_cfg_data[4:0];
                    CFG_BIN_CYCLES:    r_bin_cycles    <= i_cfg_data;
                    CFG_WINDOW_CYCLES: r_window_cycles <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.full_clear) begin
                r_vld     <= '0;
                r_cur     <= '0;
                r_dl      <= r_item.now + 64'(n_len);
                r_win_sum <= '0;
                r_win_cnt <= '0;
            end
            if (i_cmd.fold_cur) begin
                r_tot_sum <= r_tot_sum + n_bin_a.sum;
                r_tot_cnt <= r_tot_cnt + n_bin_a.cnt;
            end
            if (i_cmd.clear_all) begin
                r_tot_sum  <= '0;
                r_tot_cnt  <= '0;
                r_peak_sum <= '0;
                r_peak_cnt <= '0;
            end
            if (i_cmd.fold_step) begin
                r_win_sum <= n_win_sum;
                r_win_cnt <= n_win_cnt;
                r_tot_sum <= r_tot_sum + n_bin_a.sum;
                r_tot_cnt <= r_tot_cnt + n_bin_a.cnt;
                r_vld[r_tmp[IW-1:0]] <= 1'b0;
                r_cur <= r_tmp[IW-1:0];
            end
            if (i_cmd.peak) begin
                if (r_win_sum > r_peak_sum) begin
                    r_peak_sum <= r_win_sum;
                end
                if (r_win_cnt > r_peak_cnt) begin
                    r_peak_cnt <= r_win_cnt;
                end
            end
            if (i_cmd.dl_adv) begin
                r_dl <= r_dl + r_prod;
            end
            if (i_cmd.mod_fix) begin
                r_cur <= (n_modsum >= {1'b0, n_bins}) ?
                         IW'(n_modsum - {1'b0, n_bins}) : IW'(n_modsum);
            end
            if (i_cmd.add_wr) begin
                r_vld[r_cur] <= 1'b1;
            end
        end
    end

    // working registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_va   <= r_vld[r_cur];
        r_vb   <= r_vld[r_tmp[IW-1:0]];
        r_prod <= r_k * n_len;
        if (i_cmd.load_item) begin
            r_item <= i_item;
        end
        if (i_cmd.set_k) begin
            r_k   <= n_knew;
            r_cnt <= (n_knew < 32'(n_bins)) ? n_knew[NB-1:0] : n_bins;
            r_tmp <= NB'(r_cur) + NB'(1);
        end
        if (i_cmd.norm) begin
            r_tmp <= r_tmp - n_bins;
        end
        if (i_cmd.fold_step) begin
            r_cnt <= r_cnt - NB'(1);
        end
        if (i_cmd.next) begin
            r_tmp <= NB'(r_cur) + NB'(1);
        end
        if (i_cmd.frac_init) begin
            r_wq   <= div_quo;
            r_fr   <= FRAC_W'(div_rem) * FRAC_W'(LOAD_SCALE);
            r_fd   <= FRAC_W'({r_win_cnt, 6'b0});
            r_frac <= '0;
            r_fi   <= 3'(FRAC_STEPS);
        end
        if (i_cmd.frac_step) begin
            if (r_fr >= r_fd) begin
                r_fr   <= r_fr - r_fd;
                r_frac <= {r_frac[FRAC_STEPS-2:0], 1'b1};
            end else begin
                r_frac <= {r_frac[FRAC_STEPS-2:0], 1'b0};
            end
            r_fd <= r_fd >> 1;
            r_fi <= r_fi - 3'd1;
        end
        if (i_cmd.cap_t) begin
            r_tq <= div_quo;
        end
    end

    // load percent: whole part times the scale plus the fraction digits
    assign n_load = 39'(r_wq[30:0]) * 39'(LOAD_SCALE) + 39'(r_frac);
    assign n_load_sat = (r_wq > SAT31 || n_load > 39'(SAT31)) ? SAT31[30:0] : n_load[30:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_res.window_sum   <= r_win_sum;
            o_res.window_count <= r_win_cnt;
            o_res.peak_sum     <= r_peak_sum;
            o_res.peak_count   <= r_peak_cnt;
            o_res.total_sum    <= r_tot_sum;
            o_res.total_count  <= r_tot_cnt;
            o_res.load_percent <= (r_win_cnt == '0) ? '0 : n_load_sat;
            o_res.window_avg   <= (r_win_cnt == '0) ? '0 :
                                  (r_wq > SAT31) ? SAT31[30:0] : r_wq[30:0];
            o_res.total_avg    <= (r_tot_cnt == '0) ? '0 :
                                  (r_tq > SAT31) ? SAT31[30:0] : r_tq[30:0];
        end
    end

    assign o_stat.act_clear  = r_item.action;
    assign o_stat.past       = (r_item.now > r_dl);
    assign o_stat.far        = (n_gap > 64'(r_window_cycles));
    assign o_stat.div_busy   = div_busy;
    assign o_stat.k_gt_n     = (r_k > 32'(n_bins));
    assign o_stat.norm_req   = (r_tmp >= n_bins);
    assign o_stat.steps_done = (r_cnt == '0);
    assign o_stat.w_zero     = (r_win_cnt == '0);
    assign o_stat.t_zero     = (r_tot_cnt == '0);
    assign o_stat.frac_done  = (r_fi == '0);

endmodule

### rtl/sliding_window_rate_gauge.sv
// Sliding-window rate gauge. Each transfer on the item channel carries a
// tick timestamp, an action and a sum/count pair; each item yields exactly
// one result transfer with window, peak and all-time statistics plus the
// load percentage and the window and all-time averages (saturated to 31
// bits, zero when the count is zero). One item is processed at a time: the
// block does its bookkeeping, a normalise, fold and peak step per closed
// bin (up to the active bin count), and one pass of the shared radix-2
// divider for each division it needs: one to find how many bins have
// elapsed, one more when that exceeds the active bins, one for the window
// average followed by a bit-serial load fraction, and one for the all-time
// average. A finished result sits in an output register, so the next item
// is taken while it waits. Configuration writes are accepted at any cycle
// and must only be issued while no item is in flight. Bin storage needs no
// clearing pass: per-bin valid bits make a cleared bin read as zero.
module sliding_window_rate_gauge
    import swr_pkg::*;
#(
    parameter int MAX_BINS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // item channel
    input  logic                  i_item_valid,
    output logic                  o_item_ready,
    input  t_item                 i_item,
    // result channel
    output logic                  o_res_valid,
    input  logic                  i_res_ready,
    output t_result               o_res,
    // configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;

    // Register writes are always accepted.
    assign o_cfg_ready = 1'b1;

    // Sequence item work: advance, clear, add, then the divisions.
    swr_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (i_item_valid),
        .o_item_ready (o_item_ready),
        .o_res_valid  (o_res_valid),
        .i_res_ready  (i_res_ready),
        .i_stat       (stat),
        .o_cmd        (cmd)
    );

    // Hold bins, window and totals; run the divider and format results.
    swr_dp #(
        .MAX_BINS (MAX_BINS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid & o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_item      (i_item),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_res       (o_res)
    );

endmodule

### rtl/swr_chk.sv
module swr_chk
    import swr_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_item_valid,
    input logic                  o_item_ready,
    input t_item                 i_item,
    input logic                  o_res_valid,
    input logic                  i_res_ready,
    input t_result               o_res,
    input logic                  i_cfg_valid,
    input logic                  o_cfg_ready,
    input logic [CFG_IDX_W-1:0]  i_cfg_index,
    input logic [CFG_DATA_W-1:0] i_cfg_data
);

    // A pending result holds until transferred.
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !i_res_ready |=> o_res_valid && $stable(o_res))
        else $error("result dropped or changed while stalled");

    // The block works on one item at a time.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_item_valid && o_item_ready |=> !o_item_ready)
        else $error("item taken while busy");

    // The peak never falls below the current window.
    a_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> o_res.peak_sum >= o_res.window_sum &&
                        o_res.peak_count >= o_res.window_count)
        else $error("peak below window");

    // A zero window count gives a zero load percent and window average.
    a_zero_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.window_count == '0 |->
            o_res.load_percent == '0 && o_res.window_avg == '0)
        else $error("nonzero average with empty window");

endmodule

bind sliding_window_rate_gauge swr_chk u_swr_chk (.*);
